### rtl/rws_pkg.sv
// Shared types and constants for the roulette wheel selector.
package rws_pkg;

  // Fixed field widths.
  localparam int FIT_W       = 16;
  localparam int RND_W       = 32;
  localparam int TOTAL_W     = 24;
  localparam int OFFSET_W    = 8;
  localparam int OUT_IDX_W   = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int DIV_CNT_W   = $clog2(RND_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_OFFSET   = 2'd1;

  // Configuration reset values.
  localparam logic [FIT_W-1:0]    ZERO_THRESHOLD_RST = 16'd1;
  localparam logic [OFFSET_W-1:0] TOTAL_OFFSET_RST   = 8'd1;

  // Saturation limit of the fitness total.
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_SELECT = 2'd2,
    OP_ELITE  = 2'd3
  } op_t;

  // Classified command as it travels through the queue.
  typedef struct packed {
    op_t              op;
    logic [FIT_W-1:0] value;
    logic [RND_W-1:0] rnd;
  } cmd_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  // Configuration register contents.
  typedef struct packed {
    logic [FIT_W-1:0]    zero_threshold;
    logic [OFFSET_W-1:0] total_offset;
  } cfg_t;

endpackage

### rtl/rws_front.sv
// Front end: accepts input words, decodes the operation and applies the zero threshold.
module rws_front import rws_pkg::*; (
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_operation,
  input  logic [FIT_W-1:0] in_fitness_value,
  input  logic [RND_W-1:0] in_random_word,
  input  cfg_t             cfg,
  input  q_stat_t          q_stat,
  output logic             push,
  output cmd_t             push_cmd
);

  // Hold off the sender while the queue has no room.
  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  // Build the command; loads at or below the threshold are stored as zero.
  always_comb begin
    push_cmd.op  = op_t'(in_operation);
    push_cmd.rnd = in_random_word;
    if (in_fitness_value <= cfg.zero_threshold) begin
      push_cmd.value = '0;
    end else begin
      push_cmd.value = in_fitness_value;
    end
  end

endmodule

### rtl/rws_queue.sv
// Short command queue between the front end and the selection engine.
module rws_queue import rws_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head_cmd,
  output q_stat_t q_stat
);

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage carries payload only.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head_cmd     = entry_r[rd_ptr_r];
  assign q_stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.valid = (count_r != '0);

endmodule

### rtl/rws_back.sv
// Selection engine: fitness store, running total and maximum, modulo unit and scan.
module rws_back import rws_pkg::*; #(
  parameter int POP_SIZE = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  cmd_t                 head_cmd,
  input  q_stat_t              q_stat,
  output logic                 pop,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [OUT_IDX_W-1:0] out_picked_index,
  output logic [FIT_W-1:0]     out_picked_fitness,
  output logic                 out_past_end
);

  localparam int IDX_W  = (POP_SIZE > 1) ? $clog2(POP_SIZE) : 1;
  localparam int CNT_W  = $clog2(POP_SIZE + 1);
  localparam int SUM_W  = (FIT_W + CNT_W > TOTAL_W) ? FIT_W + CNT_W : TOTAL_W + 1;
  localparam int EXT_W  = (IDX_W > OUT_IDX_W) ? IDX_W : OUT_IDX_W;
  localparam int TEXT_W = TOTAL_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   is_elite_r, is_elite_nxt;
  logic [CNT_W-1:0]       loaded_r, loaded_nxt;
  logic [TOTAL_W-1:0]     total_r, total_nxt;
  logic [FIT_W-1:0]       max_r, max_nxt;
  logic [CNT_W-1:0]       cursor_r, cursor_nxt;
  logic [TOTAL_W-1:0]     ball_r, ball_nxt;
  logic [RND_W-1:0]       dvd_r, dvd_nxt;
  logic [DIV_CNT_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic [CNT_W-1:0]       issue_r, issue_nxt;
  logic                   rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]       rd_idx_r, rd_idx_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_IDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic [FIT_W-1:0]       out_fit_r, out_fit_nxt;
  logic                   out_past_r, out_past_nxt;

  logic [FIT_W-1:0]       fit_mem [POP_SIZE];
  logic [FIT_W-1:0]       rd_data_r;
  logic                   wr_en;

  logic                   out_free;
  logic [TEXT_W-1:0]      tot_sum;
  logic [TEXT_W-1:0]      div_shift;
  logic                   div_ge;
  logic [TOTAL_W-1:0]     div_rem;
  logic [SUM_W-1:0]       sum_sel;
  logic                   scan_last;
  logic [EXT_W-1:0]       rd_idx_ext;

  // The output register is free when empty or being taken this cycle.
  assign out_free = !out_valid_r || !out_stall;

  // Saturating total update for a load.
  assign tot_sum = {1'b0, total_r} + TEXT_W'(head_cmd.value);

  // One restoring step of the modulo unit.
  assign div_shift = {ball_r, dvd_r[RND_W-1]};
  assign div_ge    = (div_shift >= {1'b0, total_r});
  assign div_rem   = div_ge ? TOTAL_W'(div_shift - {1'b0, total_r})
                            : div_shift[TOTAL_W-1:0];

  // Scan datapath on the entry read in the previous cycle.
  assign sum_sel    = sum_r + SUM_W'(rd_data_r);
  assign scan_last  = (CNT_W'(rd_idx_r) == loaded_r - CNT_W'(1));
  assign rd_idx_ext = EXT_W'(rd_idx_r);

  // Command decode, modulo sequencing and scan control.
  always_comb begin
    state_nxt     = state_r;
    is_elite_nxt  = is_elite_r;
    loaded_nxt    = loaded_r;
    total_nxt     = total_r;
    max_nxt       = max_r;
    cursor_nxt    = cursor_r;
    ball_nxt      = ball_r;
    dvd_nxt       = dvd_r;
    div_cnt_nxt   = div_cnt_r;
    issue_nxt     = issue_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_idx_nxt   = out_idx_r;
    out_fit_nxt   = out_fit_r;
    out_past_nxt  = out_past_r;
    pop           = 1'b0;
    wr_en         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (q_stat.valid) begin
          case (head_cmd.op)
            OP_CLEAR: begin
              pop        = 1'b1;
              loaded_nxt = '0;
              total_nxt  = TOTAL_W'(cfg.total_offset);
              max_nxt    = '0;
              cursor_nxt = '0;
            end
            OP_LOAD: begin
              pop = 1'b1;
              if (loaded_r < CNT_W'(POP_SIZE)) begin
                wr_en      = 1'b1;
                loaded_nxt = loaded_r + CNT_W'(1);
                total_nxt  = tot_sum[TOTAL_W] ? TOTAL_MAX : tot_sum[TOTAL_W-1:0];
                if (head_cmd.value > max_r) begin
                  max_nxt = head_cmd.value;
                end
              end
            end
            OP_SELECT: begin
              if (out_free) begin
                pop          = 1'b1;
                is_elite_nxt = 1'b0;
                if (loaded_r == '0) begin
                  out_valid_nxt = 1'b1;
                  out_idx_nxt   = '0;
                  out_fit_nxt   = '0;
                  out_past_nxt  = 1'b1;
                end else if (total_r == '0) begin
                  ball_nxt  = '0;
                  issue_nxt = '0;
                  sum_nxt   = '0;
                  state_nxt = ST_SCAN;
                end else begin
                  ball_nxt    = '0;
                  dvd_nxt     = head_cmd.rnd;
                  div_cnt_nxt = DIV_CNT_W'(RND_W - 1);
                  state_nxt   = ST_DIV;
                end
              end
            end
            OP_ELITE: begin
              if (out_free) begin
                pop          = 1'b1;
                is_elite_nxt = 1'b1;
                if (loaded_r == '0 || cursor_r >= loaded_r) begin
                  out_valid_nxt = 1'b1;
                  out_idx_nxt   = '0;
                  out_fit_nxt   = '0;
                  out_past_nxt  = 1'b1;
                end else begin
                  issue_nxt = cursor_r;
                  state_nxt = ST_SCAN;
                end
              end
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end

      ST_DIV: begin
        ball_nxt    = div_rem;
        dvd_nxt     = {dvd_r[RND_W-2:0], 1'b0};
        div_cnt_nxt = div_cnt_r - DIV_CNT_W'(1);
        if (div_cnt_r == '0) begin
          issue_nxt = '0;
          sum_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Issue the next read while the previous entry is checked.
        if (issue_r < loaded_r) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = issue_r[IDX_W-1:0];
          issue_nxt  = issue_r + CNT_W'(1);
        end
        if (rd_vld_r) begin
          sum_nxt = sum_sel;
          if (!is_elite_r) begin
            if (sum_sel > SUM_W'(ball_r) || scan_last) begin
              out_valid_nxt = 1'b1;
              out_idx_nxt   = rd_idx_ext[OUT_IDX_W-1:0];
              out_fit_nxt   = rd_data_r;
              out_past_nxt  = !(sum_sel > SUM_W'(ball_r));
              rd_vld_nxt    = 1'b0;
              state_nxt     = ST_IDLE;
            end
          end else begin
            if (rd_data_r == max_r) begin
              out_valid_nxt = 1'b1;
              out_idx_nxt   = rd_idx_ext[OUT_IDX_W-1:0];
              out_fit_nxt   = rd_data_r;
              out_past_nxt  = 1'b0;
              cursor_nxt    = CNT_W'(rd_idx_r) + CNT_W'(1);
              rd_vld_nxt    = 1'b0;
              state_nxt     = ST_IDLE;
            end else if (scan_last) begin
              out_valid_nxt = 1'b1;
              out_idx_nxt   = '0;
              out_fit_nxt   = '0;
              out_past_nxt  = 1'b1;
              rd_vld_nxt    = 1'b0;
              state_nxt     = ST_IDLE;
            end
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      loaded_r    <= '0;
      total_r     <= TOTAL_W'(TOTAL_OFFSET_RST);
      max_r       <= '0;
      cursor_r    <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      total_r     <= total_nxt;
      max_r       <= max_nxt;
      cursor_r    <= cursor_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    is_elite_r <= is_elite_nxt;
    ball_r     <= ball_nxt;
    dvd_r      <= dvd_nxt;
    div_cnt_r  <= div_cnt_nxt;
    issue_r    <= issue_nxt;
    rd_idx_r   <= rd_idx_nxt;
    sum_r      <= sum_nxt;
    out_idx_r  <= out_idx_nxt;
    out_fit_r  <= out_fit_nxt;
    out_past_r <= out_past_nxt;
  end

  // Fitness store: one write port for loads, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      fit_mem[loaded_r[IDX_W-1:0]] <= head_cmd.value;
    end
    rd_data_r <= fit_mem[issue_r[IDX_W-1:0]];
  end

  assign out_valid          = out_valid_r;
  assign out_picked_index   = out_idx_r;
  assign out_picked_fitness = out_fit_r;
  assign out_past_end       = out_past_r;

endmodule

### rtl/roulette_wheel_selector.sv
// Roulette wheel selector top level: configuration registers, front end, queue and engine.
//
// Input channel (in_valid, in_stall): each word carries an operation, a fitness and a
// random word. Clear and load words produce no result; select and elite words produce
// exactly one word on the result channel (out_valid, out_stall).
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): index 0 is the zero
// threshold, index 1 the total offset; cfg_ready is always high. Write it only while idle.
// A two-entry queue decouples the front end from the engine, so words are taken while a
// result waits in the output register.
// Operation: clear and load are handled by the engine straight from idle. A select with
// entries loaded runs the bit-serial modulo unit (skipped when the total is zero) and
// then scans the stored entries in order, each read through the registered store port.
// An elite request scans from the cursor. The modulo loop handles one bit per cycle.
// Reset: loaded count, maximum and cursor clear, the total takes the offset reset value 1,
// the threshold resets to 1. No clearing pass is needed.
// When the receiver stalls, the result holds in the output register and the engine waits
// before starting the next select or elite; loads and clears keep flowing.
module roulette_wheel_selector import rws_pkg::*; #(
  parameter int POP_SIZE = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_operation,
  input  logic [FIT_W-1:0]      in_fitness_value,
  input  logic [RND_W-1:0]      in_random_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_IDX_W-1:0]  out_picked_index,
  output logic [FIT_W-1:0]      out_picked_fitness,
  output logic                  out_past_end,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg_r;
  q_stat_t q_stat;
  cmd_t    push_cmd;
  cmd_t    head_cmd;
  logic    push;
  logic    pop;

  // Configuration registers; writes to unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zero_threshold <= ZERO_THRESHOLD_RST;
      cfg_r.total_offset   <= TOTAL_OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ZERO_THRESHOLD: cfg_r.zero_threshold <= cfg_data;
        CFG_TOTAL_OFFSET:   cfg_r.total_offset   <= cfg_data[OFFSET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end decodes and classifies input words.
  rws_front u_front (
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_fitness_value (in_fitness_value),
    .in_random_word   (in_random_word),
    .cfg              (cfg_r),
    .q_stat           (q_stat),
    .push             (push),
    .push_cmd         (push_cmd)
  );

  // Command queue.
  rws_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  // Selection engine.
  rws_back #(
    .POP_SIZE (POP_SIZE)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .head_cmd           (head_cmd),
    .q_stat             (q_stat),
    .pop                (pop),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_picked_index   (out_picked_index),
    .out_picked_fitness (out_picked_fitness),
    .out_past_end       (out_past_end)
  );

`ifndef SYNTHESIS
  // The engine never takes a command from an empty queue.
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.valid)
    else $error("command popped from an empty queue");

  // An accepted word leaves the queue non-empty in the next cycle.
  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> q_stat.valid)
    else $error("queue empty right after a push");

  // A select or elite never starts while a stalled result still occupies the output.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && (head_cmd.op == OP_SELECT || head_cmd.op == OP_ELITE))
      |-> !(out_valid && out_stall))
    else $error("result request started over a pending result");
`endif

endmodule
